### rtl/core/glwf_pkg.sv
// shared types and constants for the gradient lattice wiener filter
// used by every module in rtl/core but glwf_chk; no dependencies
`default_nettype none

package glwf_pkg;

    localparam int MAX_ORDER_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ORDER_W    = 5;
    localparam int COEF_Q_W   = 16;

    localparam logic [ORDER_W-1:0]  ORDER_RST  = 5'd4;
    localparam logic [COEF_Q_W-1:0] LAMBDA_RST = 16'd64880;
    localparam logic [COEF_Q_W-1:0] BETA_RST   = 16'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL_ORDER   = 2'd0,
        CFG_FORGET_FACTOR = 2'd1,
        CFG_STEP_SIZE     = 2'd2
    } t_cfg_idx;

    // datapath widths
    localparam int SMP_W     = 16;
    localparam int SAMPLE_SH = 13;   // q1.15 -> q4.28
    localparam int Q_W       = 32;   // q4.28 coefficients and errors
    localparam int E_W       = 48;   // q16.32 energies
    localparam int MUL_W     = 33;   // shared multiplier operand width
    localparam int DIV_SH    = 16;   // gradient step scale 2^16
    localparam int NUM_W     = 54;   // |n| * beta
    localparam int QUO_W     = 2 * DIV_SH;

    typedef struct packed {
        logic signed [Q_W-1:0] lw;   // ladder weight p
        logic signed [Q_W-1:0] gm;   // reflection coef p-1
        logic signed [Q_W-1:0] db;   // delayed backward error p-1
        logic [E_W-1:0]        se;   // stage energy p-1
        logic [E_W-1:0]        be;   // backward energy p
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [E_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

### rtl/core/glwf_mul.sv
// shared signed multiplier with a registered product
// uses glwf_pkg for the operand width
`default_nettype none

module glwf_mul (
    input  logic                                  i_clk,
    input  logic signed [glwf_pkg::MUL_W-1:0]     i_a,
    input  logic signed [glwf_pkg::MUL_W-1:0]     i_b,
    output logic signed [2*glwf_pkg::MUL_W-1:0]   o_prod
);
    import glwf_pkg::*;

    logic signed [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### rtl/core/glwf_div.sv
// bit-serial divider for the normalized gradient step, quotient clamped to 2^31
// uses glwf_pkg for the request and response structs
`default_nettype none

module glwf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  glwf_pkg::t_div_req i_req,
    output glwf_pkg::t_div_rsp o_rsp
);
    import glwf_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam logic [QUO_W-1:0] QMAX = {1'b1, {(QUO_W-1){1'b0}}};

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [E_W-1:0]   r_rem;
    logic [E_W-1:0]   r_den;
    logic [QUO_W-1:0] r_sh;
    logic [QUO_W-1:0] r_q;
    logic [E_W:0]     w_trial;
    logic [E_W:0]     w_diff;
    logic             w_ge;
    logic [E_W-1:0]   w_num_hi;

    assign w_num_hi = E_W'(i_req.num[NUM_W-1:DIV_SH]);
    assign w_trial  = {r_rem, r_sh[QUO_W-1]};
    assign w_ge     = w_trial >= {1'b0, r_den};
    assign w_diff   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_den <= i_req.den;
                if (w_num_hi >= i_req.den) begin
                    // quotient at least 2^32, clamps
                    r_q    <= QMAX;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= w_num_hi;
                    r_sh   <= {i_req.num[DIV_SH-1:0], {DIV_SH{1'b0}}};
                    r_cnt  <= CNT_W'(QUO_W);
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[E_W-1:0] : w_trial[E_W-1:0];
                r_q    <= {r_q[QUO_W-2:0], w_ge};
                r_sh   <= r_sh << 1;
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = (r_q > QMAX) ? QMAX : r_q;

endmodule

`default_nettype wire

### rtl/core/glwf_mem.sv
// per-stage state memory, one entry per lattice stage, registered read data
// valid bit per entry so reset and restart clear it at once; uses glwf_pkg
`default_nettype none

module glwf_mem #(
    parameter int DEPTH = glwf_pkg::MAX_ORDER_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  glwf_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output glwf_pkg::t_entry o_rdata
);
    import glwf_pkg::*;

    t_entry           r_mem [DEPTH];
    t_entry           r_rdata;
    logic [DEPTH-1:0] r_vld;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    // entries not written since reset or clear read as zero
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

### rtl/core/gradient_lattice_wiener_filter.sv
// gradient adaptive lattice joint process estimator, one item at a time
// per item, one sequencer pass for each stage 0..m (m = order, clamped to MAX_ORDER) with up to
//   2*m + 1 coefficient updates through the serial divider
// the next item is taken once the result is in the output register; every pass
//   shares the one 33x33 multiplier and the serial divider
// reset (synchronous, active low) clears all filter state, sample count and output valid, and restores the config
`default_nettype none

module gradient_lattice_wiener_filter #(
    parameter int MAX_ORDER = glwf_pkg::MAX_ORDER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // reference_sample, primary_sample
    input  logic                                s_axis_tuser,  // restart
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // estimation_error, estimate
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [glwf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [glwf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import glwf_pkg::*;

    localparam int PW = $clog2(MAX_ORDER + 1);
    localparam int CW = (PW > ORDER_W) ? PW : ORDER_W;
    localparam int X_W = 48;   // estimate and running error accumulators
    localparam int S_W = 50;   // headroom for saturating sums

    // sequencer, one pass per stage
    typedef enum logic [23:0] {
        S_IDLE = 24'h000001,
        S_RD   = 24'h000002,   // issue entry read
        S_LD   = 24'h000004,   // capture entry
        S_L1   = 24'h000008,   // lattice: gm*w
        S_L2   = 24'h000010,
        S_L3   = 24'h000020,
        S_L4   = 24'h000040,
        S_L5   = 24'h000080,
        S_L6   = 24'h000100,
        S_L7   = 24'h000200,
        S_L8   = 24'h000400,
        S_N    = 24'h000800,   // reflection gradient term done
        S_G1   = 24'h001000,   // gradient step: |n|*beta low
        S_G2   = 24'h002000,
        S_G3   = 24'h004000,   // divider start
        S_GW   = 24'h008000,   // wait for quotient
        S_T    = 24'h010000,   // ladder: lw*eb
        S_TB   = 24'h020000,
        S_E1   = 24'h040000,
        S_E2   = 24'h080000,
        S_E3   = 24'h100000,
        S_E4   = 24'h200000,
        S_WR   = 24'h400000,   // write entry back
        S_OUT  = 24'h800000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [ORDER_W-1:0]  r_order;
    logic [COEF_Q_W-1:0] r_lambda;
    logic [COEF_Q_W-1:0] r_beta;

    // control
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_seen;
    logic          r_tgt_lw;
    logic          r_m_tvalid;

    // datapath
    logic signed [Q_W-1:0] r_ea_prev, r_eb_prev, r_ea, r_eb;
    logic signed [Q_W-1:0] r_lw, r_gm, r_w;
    logic [E_W-1:0]        r_se, r_be;
    logic [39:0]           r_sq;
    logic [E_W-1:0]        r_tmp;
    logic signed [37:0]    r_n;
    logic signed [X_W-1:0] r_xhat, r_err;
    logic [31:0]           r_m_tdata;

    // shared units
    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [2*MUL_W-1:0] w_prod;
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;
    t_entry                    w_rdata, w_wdata;

    logic                  w_in_acc;
    logic [CW-1:0]         w_m;
    logic                  w_last;
    logic [37:0]           w_mag;
    logic signed [37:0]    w_rnd;
    logic [39:0]           w_sq;
    logic [E_W-1:0]        w_esum;
    logic signed [Q_W-1:0] w_err32;
    logic signed [Q_W:0]   w_delta;
    logic signed [X_W-1:0] w_xr, w_er;

    function automatic logic signed [37:0] rnd28(input logic signed [2*MUL_W-1:0] v);
        logic signed [2*MUL_W-1:0] t;
        t = v + (2*MUL_W)'(134217728);
        return t[2*MUL_W-1:28];
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [S_W-1:0] v);
        if (v > S_W'(64'sd2147483647)) begin
            return 32'sh7FFF_FFFF;
        end else if (v < S_W'(-64'sd2147483648)) begin
            return 32'sh8000_0000;
        end
        return v[Q_W-1:0];
    endfunction

    function automatic logic [E_W-1:0] esat(input logic [S_W-1:0] v);
        return (v > S_W'({E_W{1'b1}})) ? {E_W{1'b1}} : v[E_W-1:0];
    endfunction

    function automatic logic [SMP_W-1:0] sat16(input logic signed [X_W-1:0] v);
        if (v > X_W'(32767)) begin
            return 16'h7FFF;
        end else if (v < X_W'(-32768)) begin
            return 16'h8000;
        end
        return v[SMP_W-1:0];
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    // highest stage in use: the order, clamped to the built order
    assign w_m    = (CW'(r_order) > CW'(MAX_ORDER)) ? CW'(MAX_ORDER) : CW'(r_order);
    assign w_last = (CW'(r_p) == w_m);

    // common pieces taken from the registered product, the divider quotient and other registers
    assign w_rnd   = rnd28(w_prod);
    assign w_sq    = w_prod[63:24];
    assign w_esum  = esat(S_W'({w_prod[31:0], 16'h0000}) + S_W'(r_tmp) + S_W'(r_sq));
    assign w_mag   = r_n[37] ? 38'(-r_n) : 38'(r_n);
    assign w_err32 = sat32(S_W'(r_err));
    assign w_delta = r_n[37] ? -$signed({1'b0, w_div_rsp.quo}) : $signed({1'b0, w_div_rsp.quo});
    assign w_xr    = (r_xhat + X_W'(4096)) >>> SAMPLE_SH;
    assign w_er    = (r_err + X_W'(4096)) >>> SAMPLE_SH;

    // multiplier operands; the product comes from the multiplier's output register
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_L1: begin w_mul_a = MUL_W'(r_gm);      w_mul_b = MUL_W'(r_w);       end
            S_L2: begin w_mul_a = MUL_W'(r_gm);      w_mul_b = MUL_W'(r_ea_prev); end
            S_L3: begin w_mul_a = MUL_W'(r_ea_prev); w_mul_b = MUL_W'(r_ea_prev); end
            S_L4: begin w_mul_a = MUL_W'(r_w);       w_mul_b = MUL_W'(r_w);       end
            S_L5: begin
                w_mul_a = $signed(MUL_W'(r_se[31:0]));
                w_mul_b = $signed(MUL_W'(r_lambda));
            end
            S_L6: begin
                w_mul_a = $signed(MUL_W'(r_se[E_W-1:32]));
                w_mul_b = $signed(MUL_W'(r_lambda));
            end
            S_L7: begin w_mul_a = MUL_W'(r_ea);      w_mul_b = MUL_W'(r_w);       end
            S_L8: begin w_mul_a = MUL_W'(r_eb);      w_mul_b = MUL_W'(r_ea_prev); end
            S_G1: begin
                w_mul_a = $signed(MUL_W'(w_mag[31:0]));
                w_mul_b = $signed(MUL_W'(r_beta));
            end
            S_G2: begin
                w_mul_a = $signed(MUL_W'(w_mag[36:32]));
                w_mul_b = $signed(MUL_W'(r_beta));
            end
            S_T:  begin w_mul_a = MUL_W'(r_lw);      w_mul_b = MUL_W'(r_eb);      end
            S_TB: begin w_mul_a = MUL_W'(r_eb);      w_mul_b = MUL_W'(r_eb);      end
            S_E1: begin
                w_mul_a = $signed(MUL_W'(r_be[31:0]));
                w_mul_b = $signed(MUL_W'(r_lambda));
            end
            S_E2: begin
                w_mul_a = $signed(MUL_W'(r_be[E_W-1:32]));
                w_mul_b = $signed(MUL_W'(r_lambda));
            end
            S_E3: begin w_mul_a = MUL_W'(w_err32);   w_mul_b = MUL_W'(r_eb);      end
            default: ;
        endcase
    end

    // divider request: |n|*beta = hi*beta<<32 + lo*beta
    assign w_div_req.start = (r_state == S_G3);
    assign w_div_req.num   = (NUM_W'(w_prod[20:0]) << 32) + NUM_W'(r_tmp);
    assign w_div_req.den   = r_tgt_lw ? r_be : r_se;

    assign w_wdata.lw = r_lw;
    assign w_wdata.gm = r_gm;
    assign w_wdata.db = r_eb_prev;
    assign w_wdata.se = r_se;
    assign w_wdata.be = r_be;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_RD;
            S_RD:   n_state = S_LD;
            S_LD:   n_state = (r_p == '0) ? S_T : S_L1;
            S_L1:   n_state = S_L2;
            S_L2:   n_state = S_L3;
            S_L3:   n_state = S_L4;
            S_L4:   n_state = S_L5;
            S_L5:   n_state = S_L6;
            S_L6:   n_state = S_L7;
            S_L7:   n_state = S_L8;
            S_L8:   n_state = S_N;
            S_N:    n_state = (r_se != '0) ? S_G1 : S_T;
            S_G1:   n_state = S_G2;
            S_G2:   n_state = S_G3;
            S_G3:   n_state = S_GW;
            S_GW:   if (w_div_rsp.done) n_state = r_tgt_lw ? S_WR : S_T;
            S_T:    n_state = S_TB;
            S_TB:   n_state = S_E1;
            S_E1:   n_state = S_E2;
            S_E2:   n_state = S_E3;
            S_E3:   n_state = S_E4;
            S_E4:   n_state = (r_p <= r_seen && r_be != '0) ? S_G1 : S_WR;
            S_WR:   n_state = w_last ? S_OUT : S_RD;
            S_OUT:  if (!r_m_tvalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_order    <= ORDER_RST;
            r_lambda   <= LAMBDA_RST;
            r_beta     <= BETA_RST;
            r_seen     <= '0;
            r_p        <= '0;
            r_tgt_lw   <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODEL_ORDER:   r_order  <= i_cfg_data[ORDER_W-1:0];
                    CFG_FORGET_FACTOR: r_lambda <= i_cfg_data;
                    CFG_STEP_SIZE:     r_beta   <= i_cfg_data;
                    default: ;   // unknown index, write dropped
                endcase
            end

            // output register drains; a new result in S_OUT refills it below
            if (r_m_tvalid && m_axis_tready && r_state != S_OUT) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        // restart clears the sample count, memory is cleared alongside
                        if (s_axis_tuser) r_seen <= '0;
                        r_ea_prev <= Q_W'($signed(s_axis_tdata[31:16])) <<< SAMPLE_SH;
                        r_eb_prev <= Q_W'($signed(s_axis_tdata[31:16])) <<< SAMPLE_SH;
                        r_err     <= X_W'($signed(s_axis_tdata[15:0])) <<< SAMPLE_SH;
                        r_xhat    <= '0;
                        r_p       <= '0;
                    end
                end
                S_LD: begin
                    r_lw <= w_rdata.lw;
                    r_gm <= w_rdata.gm;
                    r_w  <= w_rdata.db;
                    r_se <= w_rdata.se;
                    r_be <= w_rdata.be;
                    // stage zero: both errors are the reference itself
                    r_ea <= r_ea_prev;
                    r_eb <= r_eb_prev;
                end
                S_L2: r_ea  <= sat32(S_W'(r_ea_prev) - S_W'(w_rnd));
                S_L3: r_eb  <= sat32(S_W'(r_w) - S_W'(w_rnd));
                S_L4: r_sq  <= w_sq;
                S_L5: r_sq  <= r_sq + w_sq;
                S_L6: r_tmp <= E_W'(w_prod[47:16]);
                S_L7: r_se  <= w_esum;
                S_L8: r_n   <= w_rnd;
                S_N: begin
                    r_n      <= r_n + w_rnd;
                    r_tgt_lw <= 1'b0;
                end
                S_G2: r_tmp <= w_prod[E_W-1:0];
                S_GW: begin
                    if (w_div_rsp.done) begin
                        if (r_tgt_lw) begin
                            r_lw <= sat32(S_W'(r_lw) + S_W'(w_delta));
                        end else begin
                            r_gm <= sat32(S_W'(r_gm) + S_W'(w_delta));
                        end
                    end
                end
                S_TB: begin
                    r_xhat <= r_xhat + X_W'(w_rnd);
                    r_err  <= r_err - X_W'(w_rnd);
                end
                S_E1: r_sq  <= w_sq;
                S_E2: r_tmp <= E_W'(w_prod[47:16]);
                S_E3: r_be  <= w_esum;
                S_E4: begin
                    r_n      <= w_rnd;
                    r_tgt_lw <= 1'b1;
                end
                S_WR: begin
                    r_ea_prev <= r_ea;
                    r_eb_prev <= r_eb;
                    if (!w_last) r_p <= r_p + 1'b1;
                end
                S_OUT: begin
                    if (!r_m_tvalid || m_axis_tready) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {sat16(w_er), sat16(w_xr)};
                        if (r_seen < PW'(MAX_ORDER)) r_seen <= r_seen + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    glwf_mem #(
        .DEPTH (MAX_ORDER + 1),
        .AW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_in_acc && s_axis_tuser),
        .i_we    (r_state == S_WR),
        .i_waddr (r_p),
        .i_wdata (w_wdata),
        .i_raddr (r_p),
        .o_rdata (w_rdata)
    );

    glwf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    glwf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

`default_nettype wire

### rtl/core/glwf_chk.sv
// port-level checks for the gradient lattice wiener filter, bound to the top level
// depends only on the top level's ports
`default_nettype none

module glwf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // a new result only appears while the input side is busy
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without an item in work");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind gradient_lattice_wiener_filter glwf_chk u_glwf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
